@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while in reset
`define GPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while in reset
`define GPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GPP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/gpp_pkg.sv @@
// ----------------------------------------------------------------------------
// gpp_pkg
// Types and constants of the galvo point playback core.
// ----------------------------------------------------------------------------
`default_nettype none

package gpp_pkg;

    localparam int RING_DEPTH_DEF = 8;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_FLIP_X     = 2'd0,
        REG_FLIP_Y     = 2'd1,
        REG_DAC_OFFSET = 2'd2
    } t_gpp_reg_idx;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_PUSH = 1'b1
    } t_gpp_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_gpp_state;

    typedef struct packed {
        logic              cmd;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [7:0]        point_power;
        logic [15:0]       dwell_ticks;
    } t_gpp_in;

    typedef struct packed {
        logic        accepted;
        logic        x_write;
        logic [15:0] x_code;
        logic        y_write;
        logic [15:0] y_code;
        logic [7:0]  laser_duty;
        logic        is_moving;
        logic        point_released;
    } t_gpp_out;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] value;
    } t_gpp_cfg_wr;

    typedef struct packed {
        logic        flip_x;
        logic        flip_y;
        logic [15:0] dac_offset;
    } t_gpp_cfg;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [7:0]  power;
        logic [15:0] dwell;
    } t_gpp_entry;

    // DAC code: optionally negated position plus offset, low 16 bits
    function automatic logic [15:0] make_code(input logic [15:0] pos,
                                              input logic        inv,
                                              input logic [15:0] offset);
        logic [15:0] p;
        p = inv ? (16'd0 - pos) : pos;
        return p + offset;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/gpp_chan_if.sv @@
// ----------------------------------------------------------------------------
// gpp_chan_if
// Valid/ready channel carrying one request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpp_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gpp_ring_mem.sv @@
// ----------------------------------------------------------------------------
// gpp_ring_mem
// Point ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gpp_ring_mem #(
    parameter int RING_DEPTH = gpp_pkg::RING_DEPTH_DEF,
    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
    input  wire                logic        i_clk,
    input  wire                logic        i_we,
    input  wire                logic [PTR_W-1:0] i_waddr,
    input  gpp_pkg::t_gpp_entry             i_wdata,
    input  wire                logic        i_re,
    input  wire                logic [PTR_W-1:0] i_raddr,
    output gpp_pkg::t_gpp_entry             o_rdata
);
    import gpp_pkg::*;

    t_gpp_entry r_mem [RING_DEPTH];
    t_gpp_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/gpp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// gpp_cfg_regs
// Configuration register file: axis inversion and DAC offset.
// ----------------------------------------------------------------------------
`default_nettype none

module gpp_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    gpp_chan_if.sink           i_cfg,
    output gpp_pkg::t_gpp_cfg  o_cfg
);
    import gpp_pkg::*;

    t_gpp_cfg    r_cfg;
    t_gpp_cfg    n_cfg;
    t_gpp_cfg_wr wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.data;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_gpp_reg_idx'(wr.index))
                REG_FLIP_X:     n_cfg.flip_x     = wr.value[0];
                REG_FLIP_Y:     n_cfg.flip_y     = wr.value[0];
                REG_DAC_OFFSET: n_cfg.dac_offset = wr.value;
                default:        n_cfg = r_cfg;   // unmapped index, dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flip_x     <= 1'b0;
            r_cfg.flip_y     <= 1'b0;
            r_cfg.dac_offset <= 16'd2048;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/core/gpp_playback.sv @@
// ----------------------------------------------------------------------------
// gpp_playback
// Ring control, tick sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpp_playback #(
    parameter int RING_DEPTH = gpp_pkg::RING_DEPTH_DEF,
    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gpp_chan_if.sink               i_in,
    gpp_chan_if.source             o_out,
    input  gpp_pkg::t_gpp_cfg      i_cfg,
    output logic                   o_mem_we,
    output logic [PTR_W-1:0]       o_mem_waddr,
    output gpp_pkg::t_gpp_entry    o_mem_wdata,
    output logic                   o_mem_re,
    output logic [PTR_W-1:0]       o_mem_raddr,
    input  gpp_pkg::t_gpp_entry    i_mem_rdata
);
    import gpp_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(RING_DEPTH);

    t_gpp_state       r_state, n_state;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [15:0]      r_dwell, n_dwell;
    logic [15:0]      r_cur_x, n_cur_x;
    logic [15:0]      r_cur_y, n_cur_y;
    logic [7:0]       r_power, n_power;
    logic [15:0]      r_prev_x, n_prev_x;
    logic [15:0]      r_prev_y, n_prev_y;
    logic             r_moving, n_moving;
    logic             r_out_valid, n_out_valid;
    t_gpp_out         r_out, n_out;

    t_gpp_in          in_req;
    logic             in_ready;
    logic             in_acc;
    logic             do_push;
    logic             do_exec;
    logic             push_ok;
    logic             release_pt;
    logic             has_pt;
    logic             x_chg, y_chg;
    logic             moving_held;
    t_gpp_entry       push_entry;
    t_gpp_entry       rel_entry;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign in_req  = i_in.data;
    assign in_acc  = i_in.valid && in_ready;
    assign do_push = in_acc && (t_gpp_cmd'(in_req.cmd) == CMD_PUSH);
    assign do_exec = (r_state == ST_EXEC);
    assign push_ok = (r_fill < FILL_MAX);
    assign has_pt  = (r_fill != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (t_gpp_cmd'(in_req.cmd) == CMD_TICK)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        o_mem_re = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                in_ready = !r_out_valid || o_out.ready;
                o_mem_re = i_in.valid && in_ready
                           && (t_gpp_cmd'(in_req.cmd) == CMD_TICK);
            end
            ST_EXEC: begin
                in_ready = 1'b0;
                o_mem_re = 1'b0;
            end
            default: begin
                in_ready = 1'b0;
                o_mem_re = 1'b0;
            end
        endcase
    end

    assign i_in.ready  = in_ready;
    assign o_mem_raddr = r_rptr;

    // tick datapath, on the entry read out of the ring
    assign x_chg       = has_pt && (i_mem_rdata.x != r_cur_x);
    assign y_chg       = has_pt && (i_mem_rdata.y != r_cur_y);
    assign release_pt  = has_pt && (r_dwell >= i_mem_rdata.dwell);
    assign moving_held = (r_cur_x == r_prev_x && r_cur_y == r_prev_y) ? 1'b0 : r_moving;

    always_comb begin
        push_entry.x     = in_req.point_x;
        push_entry.y     = in_req.point_y;
        push_entry.power = in_req.point_power;
        push_entry.dwell = in_req.dwell_ticks;
        rel_entry        = i_mem_rdata;
        rel_entry.dwell  = 16'd0;
    end

    // ring write: push at write end, release clears dwell at read end
    always_comb begin
        o_mem_we    = (do_push && push_ok) || (do_exec && release_pt);
        o_mem_waddr = do_exec ? r_rptr : r_wptr;
        o_mem_wdata = do_exec ? rel_entry : push_entry;
    end

    always_comb begin
        n_rptr      = r_rptr;
        n_wptr      = r_wptr;
        n_fill      = r_fill;
        n_dwell     = r_dwell;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_power     = r_power;
        n_prev_x    = r_prev_x;
        n_prev_y    = r_prev_y;
        n_moving    = r_moving;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (do_push) begin
            if (push_ok) begin
                n_wptr = ptr_inc(r_wptr);
                n_fill = r_fill + 1'b1;
            end
            n_out                = '0;
            n_out.accepted       = push_ok;
            n_out.laser_duty     = (r_moving || r_dwell != 16'd0) ? r_power : 8'd0;
            n_out.is_moving      = r_moving;
            n_out_valid          = 1'b1;
        end else if (do_exec) begin
            n_prev_x = r_cur_x;
            n_prev_y = r_cur_y;
            n_moving = moving_held || x_chg || y_chg;
            if (has_pt) begin
                n_cur_x = i_mem_rdata.x;
                n_cur_y = i_mem_rdata.y;
                n_power = i_mem_rdata.power;
                if (release_pt) begin
                    n_dwell = 16'd0;
                    n_rptr  = ptr_inc(r_rptr);
                    n_fill  = r_fill - 1'b1;
                end else begin
                    n_dwell = r_dwell + 16'd1;
                end
            end
            n_out                = '0;
            n_out.x_write        = x_chg;
            n_out.x_code         = x_chg ? make_code(i_mem_rdata.x, i_cfg.flip_x,
                                                     i_cfg.dac_offset) : 16'd0;
            n_out.y_write        = y_chg;
            n_out.y_code         = y_chg ? make_code(i_mem_rdata.y, i_cfg.flip_y,
                                                     i_cfg.dac_offset) : 16'd0;
            n_out.laser_duty     = (n_moving || n_dwell != 16'd0) ? n_power : 8'd0;
            n_out.is_moving      = n_moving;
            n_out.point_released = release_pt;
            n_out_valid          = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rptr      <= '0;
            r_wptr      <= '0;
            r_fill      <= '0;
            r_dwell     <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_power     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rptr      <= n_rptr;
            r_wptr      <= n_wptr;
            r_fill      <= n_fill;
            r_dwell     <= n_dwell;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_power     <= n_power;
            r_prev_x    <= n_prev_x;
            r_prev_y    <= n_prev_y;
            r_moving    <= n_moving;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `GPP_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_MAX)
    `GPP_ASSERT_IMP(a_exec_blocks, i_clk, i_rst_n, r_state == ST_EXEC, !in_ready)
    `GPP_ASSERT_NXT(a_tick_reads, i_clk, i_rst_n, o_mem_re, r_state == ST_EXEC)
    `GPP_ASSERT_NXT(a_release_pops, i_clk, i_rst_n, do_exec && release_pt,
                    r_fill == $past(r_fill) - 1'b1 && r_dwell == 16'd0)
    `GPP_ASSERT_NXT(a_result_out, i_clk, i_rst_n, do_exec || do_push, r_out_valid)

endmodule

`default_nettype wire

@@ rtl/core/galvo_point_playback_core.sv @@
// ----------------------------------------------------------------------------
// galvo_point_playback_core
// Laser galvo output stage: point ring, DAC code generation, laser duty.
// ----------------------------------------------------------------------------
// A push request is stored in the ring if there is room and its result is
// registered directly; a tick request first does the registered read of
// the ring memory at the read end, then updates position, dwell and ring
// state and loads the result register. Requests are taken one at a time;
// a new one is taken while the previous result still waits, as long as
// that result is drained in the same cycle or already gone. Ring contents
// need no clearing after reset; only pushed entries are ever played.
`default_nettype none

module galvo_point_playback_core #(
    parameter int RING_DEPTH = gpp_pkg::RING_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gpp_chan_if.sink     i_in,
    gpp_chan_if.source   o_out,
    gpp_chan_if.sink     i_cfg
);
    import gpp_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    t_gpp_cfg         cfg;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    t_gpp_entry       mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    t_gpp_entry       mem_rdata;

    gpp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    gpp_ring_mem #(
        .RING_DEPTH (RING_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    gpp_playback #(
        .RING_DEPTH (RING_DEPTH)
    ) u_play (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg       (cfg),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire
